// File: rtl/core/decimal_entry_calculator_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the decimal entry calculator.
// Both macros sample on clk and are disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_ENTRY_CALCULATOR_TOP_DEFINES_SVH
`define DECIMAL_ENTRY_CALCULATOR_TOP_DEFINES_SVH

// The property must hold in the same cycle as its trigger.
`define DC_ASSERT_SAME(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error(msg);

// The property must hold in the cycle after its trigger.
`define DC_ASSERT_NEXT(label, trig, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/core/dec_calc_pkg.sv
// ---------------------------------------------------------------------------
// dec_calc_pkg
// Shared types and constants of the decimal entry calculator.
// ---------------------------------------------------------------------------
package dec_calc_pkg;

	localparam int WORD_W = 32;
	localparam int BYTE_W = 8;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One quotient bit per divider step.
	localparam int DIV_STEPS = WORD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	localparam logic REQ_CHAR   = 1'b0;
	localparam logic REQ_BUTTON = 1'b1;

	localparam logic RES_ECHO   = 1'b0;
	localparam logic RES_ANSWER = 1'b1;

	localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
	localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [BYTE_W-1:0] CHAR_STAR  = 8'h2A;
	localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;

	typedef struct packed {
		logic              req_type;
		logic [BYTE_W-1:0] char_byte;
	} req_t;

	typedef struct packed {
		logic                     result_kind;
		logic [BYTE_W-1:0]        echo_byte;
		logic signed [WORD_W-1:0] left_value;
		logic [1:0]               operation;
		logic signed [WORD_W-1:0] right_value;
		logic signed [WORD_W-1:0] answer;
		logic                     divide_by_zero;
	} res_t;

	// Work handed from the front to the back.
	typedef struct packed {
		logic              is_answer;
		logic [BYTE_W-1:0] echo_byte;
		logic [WORD_W-1:0] left_value;
		op_t               operation;
		logic [WORD_W-1:0] right_value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// File: rtl/core/dec_calc_front.sv
// ---------------------------------------------------------------------------
// dec_calc_front
// Accepts requests, keeps the operand entry state and queues the work.
// ---------------------------------------------------------------------------
module dec_calc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  dec_calc_pkg::req_t  req,
	input  dec_calc_pkg::qstat_t qstat,
	output logic                push,
	output dec_calc_pkg::cmd_t  push_cmd
);

	logic [dec_calc_pkg::WORD_W-1:0] first_q;
	logic [dec_calc_pkg::WORD_W-1:0] second_q;
	logic                            on_second_q;
	logic                            digit_seen_q;
	dec_calc_pkg::op_t               op_q;

	logic                            accept;
	logic                            is_button;
	logic                            is_digit;
	logic                            is_oper;
	dec_calc_pkg::op_t               oper_code;
	logic [3:0]                      digit;
	logic [dec_calc_pkg::WORD_W-1:0] acc_sel;
	logic [dec_calc_pkg::WORD_W-1:0] acc_next;

	always_comb begin
		is_digit  = 1'b0;
		is_oper   = 1'b0;
		oper_code = dec_calc_pkg::OP_ADD;
		unique case (req.char_byte) inside
			[dec_calc_pkg::CHAR_0:dec_calc_pkg::CHAR_9]: begin
				is_digit = 1'b1;
			end
			dec_calc_pkg::CHAR_PLUS: begin
				is_oper   = 1'b1;
				oper_code = dec_calc_pkg::OP_ADD;
			end
			dec_calc_pkg::CHAR_MINUS: begin
				is_oper   = 1'b1;
				oper_code = dec_calc_pkg::OP_SUB;
			end
			dec_calc_pkg::CHAR_STAR: begin
				is_oper   = 1'b1;
				oper_code = dec_calc_pkg::OP_MUL;
			end
			dec_calc_pkg::CHAR_SLASH: begin
				is_oper   = 1'b1;
				oper_code = dec_calc_pkg::OP_DIV;
			end
			default: begin
				is_digit = 1'b0;
			end
		endcase
	end

	assign req_stall = qstat.full;
	assign accept    = req_valid && !qstat.full;
	assign is_button = (req.req_type == dec_calc_pkg::REQ_BUTTON);

	// A button with the first operand selected produces nothing.
	assign push = accept && (!is_button || on_second_q);

	always_comb begin
		push_cmd.is_answer   = is_button;
		push_cmd.echo_byte   = is_button ? '0 : req.char_byte;
		push_cmd.left_value  = first_q;
		push_cmd.operation   = op_q;
		push_cmd.right_value = second_q;
	end

	// Times ten as two shifted copies added together.
	assign digit    = 4'(req.char_byte - dec_calc_pkg::CHAR_0);
	assign acc_sel  = on_second_q ? second_q : first_q;
	assign acc_next = digit_seen_q
		? (acc_sel << 3) + (acc_sel << 1) + dec_calc_pkg::WORD_W'(digit)
		: dec_calc_pkg::WORD_W'(digit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q      <= '0;
			second_q     <= '0;
			on_second_q  <= 1'b0;
			digit_seen_q <= 1'b0;
			op_q         <= dec_calc_pkg::OP_ADD;
		end else if (accept) begin
			if (is_button) begin
				if (on_second_q) begin
					on_second_q  <= 1'b0;
					digit_seen_q <= 1'b0;
				end
			end else if (is_digit) begin
				digit_seen_q <= 1'b1;
				if (on_second_q) begin
					second_q <= acc_next;
				end else begin
					first_q <= acc_next;
				end
			end else if (is_oper) begin
				op_q         <= oper_code;
				digit_seen_q <= 1'b0;
				on_second_q  <= 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/dec_calc_queue.sv
// ---------------------------------------------------------------------------
// dec_calc_queue
// Short register queue that decouples the front from the back.
// ---------------------------------------------------------------------------
module dec_calc_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  dec_calc_pkg::cmd_t   push_cmd,
	input  logic                 pop,
	output dec_calc_pkg::cmd_t   head,
	output dec_calc_pkg::qstat_t qstat
);

	dec_calc_pkg::cmd_t                entry_q [dec_calc_pkg::QUEUE_DEPTH];
	logic [dec_calc_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [dec_calc_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [dec_calc_pkg::QCNT_W-1:0]   count_q;

	function automatic logic [dec_calc_pkg::QPTR_W-1:0] ptr_inc(
		input logic [dec_calc_pkg::QPTR_W-1:0] ptr
	);
		if (ptr == dec_calc_pkg::QPTR_W'(dec_calc_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	assign head        = entry_q[rd_ptr_q];
	assign qstat.full  = (count_q == dec_calc_pkg::QCNT_W'(dec_calc_pkg::QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/dec_calc_back.sv
// ---------------------------------------------------------------------------
// dec_calc_back
// Executes queued work: echoes, arithmetic and an iterative divider.
// ---------------------------------------------------------------------------
module dec_calc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dec_calc_pkg::qstat_t qstat,
	input  dec_calc_pkg::cmd_t   head,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output dec_calc_pkg::res_t   res
);

	typedef enum logic [2:0] {
		B_IDLE   = 3'b001,
		B_DIV    = 3'b010,
		B_FINISH = 3'b100
	} back_state_t;

	localparam int W = dec_calc_pkg::WORD_W;

	back_state_t                      state_q;
	dec_calc_pkg::cmd_t               cmd_q;
	logic [W-1:0]                     rem_q;
	logic [W-1:0]                     quo_q;
	logic [W-1:0]                     div_q;
	logic [dec_calc_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                             neg_q;
	logic                             res_valid_q;
	dec_calc_pkg::res_t               res_q;

	logic                             out_free;
	logic                             load;
	logic                             start_div;
	logic [W-1:0]                     mag_left;
	logic [W-1:0]                     mag_right;
	logic [W:0]                       rem_sh;
	logic [W:0]                       diff;
	logic [W-1:0]                     product;
	dec_calc_pkg::res_t               res_next;

	assign out_free  = !res_valid_q || !res_stall;
	assign pop       = (state_q == B_IDLE) && !qstat.empty;
	assign load      = (state_q == B_FINISH) && out_free;
	assign start_div = head.is_answer && (head.operation == dec_calc_pkg::OP_DIV)
		&& (head.right_value != '0);

	assign mag_left  = head.left_value[W-1]  ? '0 - head.left_value  : head.left_value;
	assign mag_right = head.right_value[W-1] ? '0 - head.right_value : head.right_value;

	// One restoring step per cycle.
	assign rem_sh = {rem_q, quo_q[W-1]};
	assign diff   = rem_sh - {1'b0, div_q};

	assign product = cmd_q.left_value * cmd_q.right_value;

	always_comb begin
		res_next = '0;
		if (!cmd_q.is_answer) begin
			res_next.result_kind = dec_calc_pkg::RES_ECHO;
			res_next.echo_byte   = cmd_q.echo_byte;
		end else begin
			res_next.result_kind = dec_calc_pkg::RES_ANSWER;
			res_next.left_value  = cmd_q.left_value;
			res_next.operation   = cmd_q.operation;
			res_next.right_value = cmd_q.right_value;
			case (cmd_q.operation)
				dec_calc_pkg::OP_ADD: res_next.answer = cmd_q.left_value + cmd_q.right_value;
				dec_calc_pkg::OP_SUB: res_next.answer = cmd_q.left_value - cmd_q.right_value;
				dec_calc_pkg::OP_MUL: res_next.answer = product;
				default: begin
					if (cmd_q.right_value == '0) begin
						res_next.divide_by_zero = 1'b1;
					end else begin
						res_next.answer = neg_q ? '0 - quo_q : quo_q;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
			rem_q <= '0;
			quo_q <= mag_left;
			div_q <= mag_right;
			neg_q <= head.left_value[W-1] ^ head.right_value[W-1];
		end else if (state_q == B_DIV) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
		if (load) begin
			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						cnt_q   <= '0;
						state_q <= start_div ? B_DIV : B_FINISH;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == dec_calc_pkg::DIV_CNT_W'(dec_calc_pkg::DIV_STEPS - 1)) begin
						state_q <= B_FINISH;
					end
				end
				B_FINISH: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// File: rtl/core/decimal_entry_calculator_top.sv
// ---------------------------------------------------------------------------
// decimal_entry_calculator_top
// Four-function calculator fed by serial characters and button presses.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake             Payload               Direction
//   req      req_valid/req_stall   dec_calc_pkg::req_t   into the block
//   res      res_valid/res_stall   dec_calc_pkg::res_t   out of the block
//
// The front takes one request per cycle while its two-entry queue has room.
// The back handles an echo, an add, a subtract or a multiply by dequeuing it
// and then executing into the result register, and a division through the
// restoring divider that yields one quotient bit a cycle.
// Reset is asynchronous and active low; it clears the operands, the entry
// state, the queue pointers and the result valid flag.
// A stall on the result side holds the back, which fills the queue and then
// raises req_stall; a request causes at most one result.
// ---------------------------------------------------------------------------

`include "decimal_entry_calculator_top_defines.svh"

module decimal_entry_calculator_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  dec_calc_pkg::req_t req,
	output logic               res_valid,
	input  logic               res_stall,
	output dec_calc_pkg::res_t res
);

	// Queue status, seen by both the front and the back.
	dec_calc_pkg::qstat_t qstat;

	// Work travelling from the front into the queue and out to the back.
	logic                 push;
	logic                 pop;
	dec_calc_pkg::cmd_t   push_cmd;
	dec_calc_pkg::cmd_t   head;

	// The front decodes each character and updates the operands at once, so
	// the queued work already carries the operand values that it needs.
	dec_calc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.qstat     (qstat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	dec_calc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// The back owns the result register, so a finished result can wait for
	// the consumer while the front keeps taking requests.
	dec_calc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qstat     (qstat),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Every accepted character must leave work in the queue for its echo.
	`DC_ASSERT_NEXT(a_char_queued, req_valid && !req_stall && (req.req_type == dec_calc_pkg::REQ_CHAR), !qstat.empty, "accepted character left no queued echo")

	// An answer never carries an echoed byte.
	`DC_ASSERT_SAME(a_answer_no_echo, res_valid && (res.result_kind == dec_calc_pkg::RES_ANSWER), res.echo_byte == '0, "answer result carries an echo byte")

	// A zero divisor flag only comes with a division and a zero answer.
	`DC_ASSERT_SAME(a_div_zero_answer, res_valid && res.divide_by_zero, (res.answer == '0) && (res.operation == dec_calc_pkg::OP_DIV) && (res.right_value == '0), "divide by zero flag with inconsistent answer")

endmodule
